// ----- rtl/trx_image_header_crc_check_core_assert.svh -----
// assertion macros for the trx header check core
`ifndef TRX_IMAGE_HEADER_CRC_CHECK_CORE_ASSERT_SVH
`define TRX_IMAGE_HEADER_CRC_CHECK_CORE_ASSERT_SVH

`ifndef SYNTH
`define TRX_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trx header check: implication failed");
`define TRX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trx header check: next-cycle check failed");
`else
`define TRX_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TRX_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/trx_hdr_pkg.sv -----
package trx_hdr_pkg;

  localparam int unsigned HEADER_BYTES = 28;
  localparam int unsigned CRC_START    = 12;
  localparam logic [31:0] HDR_MAGIC    = 32'h3052_4448;
  localparam logic [31:0] CRC_SEED     = 32'hffff_ffff;
  localparam logic [31:0] CRC_POLY     = 32'hedb8_8320;

  localparam int unsigned OP_QUEUE_DEPTH  = 2;
  localparam int unsigned RES_QUEUE_DEPTH = 2;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MAGIC    = 3'd1;
  localparam logic [2:0] ST_LENGTH   = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_TRUNC    = 3'd4;

  // verdict kind decided by the front part
  localparam logic [2:0] VK_NONE   = 3'd0;
  localparam logic [2:0] VK_MAGIC  = 3'd1;
  localparam logic [2:0] VK_LENGTH = 3'd2;
  localparam logic [2:0] VK_CHECK  = 3'd3;
  localparam logic [2:0] VK_TRUNC  = 3'd4;

  typedef struct packed {
    logic [7:0]  data;
    logic        restart;
    logic        crc_en;
    logic [2:0]  kind;
    logic [31:0] stored_crc;
    logic [31:0] length;
  } op_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] crc;
    logic [31:0] length;
  } res_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/trx_image_header_crc_check_core.sv -----
// channel  | direction | handshake      | fields
// image    | in        | push / full    | data_byte, first_byte, end_of_data
// verdict  | out       | pop / empty    | status, computed_crc, image_length
//
// one byte is taken per cycle while not full; the front part updates the header
// fields and index in that cycle, the back part runs one table-free byte crc
// step a cycle unless a verdict meets a full result queue. verdicts pass the
// op and result queues. full rises only when the op queue between front and
// back is full, which happens when the result queue backs up and verdicts stop
// draining. reset clears all control state and loads the crc with the seed.
`include "trx_image_header_crc_check_core_assert.svh"

module trx_image_header_crc_check_core #(
  parameter int unsigned OP_DEPTH  = trx_hdr_pkg::OP_QUEUE_DEPTH,
  parameter int unsigned RES_DEPTH = trx_hdr_pkg::RES_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        end_of_data,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic [31:0] computed_crc,
  output logic [31:0] image_length
);
  import trx_hdr_pkg::*;

  logic accept;
  logic op_push;
  logic op_pop;
  logic op_empty;
  op_t  op_in;
  op_t  op_out;
  logic res_push;
  logic res_full;
  res_t res_in;
  res_t res_out;

  assign accept = push && !full;

  trx_hdr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .first_byte  (first_byte),
    .end_of_data (end_of_data),
    .op_push     (op_push),
    .op          (op_in)
  );

  trx_hdr_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (OP_DEPTH)
  ) u_op_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (op_push),
    .wr_data (op_in),
    .rd_en   (op_pop),
    .rd_data (op_out),
    .full    (full),
    .empty   (op_empty)
  );

  trx_hdr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_empty (op_empty),
    .op       (op_out),
    .op_pop   (op_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  trx_hdr_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .rd_en   (pop && !empty),
    .rd_data (res_out),
    .full    (res_full),
    .empty   (empty)
  );

  assign status       = res_out.status;
  assign computed_crc = res_out.crc;
  assign image_length = res_out.length;

  `TRX_ASSERT_IMPL(a_res_no_overflow, clk, rst, res_push, !res_full)
  `TRX_ASSERT_IMPL(a_op_pop_nonempty, clk, rst, op_pop, !op_empty)
  `TRX_ASSERT_IMPL(a_status_legal, clk, rst, !empty, status <= ST_TRUNC)
  `TRX_ASSERT_NEXT(a_res_lands, clk, rst, res_push, !empty)
endmodule

// ----- rtl/trx_hdr_fifo.sv -----
module trx_hdr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ----- rtl/trx_hdr_front.sv -----
module trx_hdr_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             first_byte,
  input  logic             end_of_data,
  output logic             op_push,
  output trx_hdr_pkg::op_t op
);
  import trx_hdr_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  logic [1:0]  phase;
  logic [31:0] byte_index;
  logic [31:0] word_shift;
  logic [31:0] declared_length;
  logic [31:0] stored_crc;

  logic [1:0]  phase_next;
  logic [31:0] byte_index_next;
  logic [31:0] word_shift_next;
  logic [31:0] declared_length_next;
  logic [31:0] stored_crc_next;

  logic        running;
  logic [31:0] idx;
  logic [2:0]  kind;

  always_comb begin
    running              = first_byte || (phase == PH_RUN);
    idx                  = first_byte ? '0 : byte_index;
    word_shift_next      = {data_byte, (first_byte ? 24'd0 : word_shift[31:8])};
    declared_length_next = first_byte ? '0 : declared_length;
    stored_crc_next      = first_byte ? '0 : stored_crc;
    kind                 = VK_NONE;

    if (idx == 32'd3) begin
      if (word_shift_next != HDR_MAGIC) begin
        kind = VK_MAGIC;
      end
    end else if (idx == 32'd7) begin
      declared_length_next = word_shift_next;
      if (word_shift_next < 32'(HEADER_BYTES)) begin
        kind = VK_LENGTH;
      end
    end else if (idx == 32'd11) begin
      stored_crc_next = word_shift_next;
    end

    // the index is compared one wider so the last index cannot wrap onto a length
    if (kind == VK_NONE && idx >= 32'(HEADER_BYTES - 1) &&
        ({1'b0, idx} + 33'd1) == {1'b0, declared_length_next}) begin
      kind = VK_CHECK;
    end
    if (kind == VK_NONE && end_of_data) begin
      kind = VK_TRUNC;
    end

    byte_index_next = idx + 32'd1;
    phase_next      = (kind != VK_NONE) ? PH_DONE : PH_RUN;

    op_push       = accept && running;
    op.data       = data_byte;
    op.restart    = first_byte;
    op.crc_en     = (idx >= 32'(CRC_START));
    op.kind       = kind;
    op.stored_crc = stored_crc_next;
    op.length     = declared_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      byte_index      <= '0;
      word_shift      <= '0;
      declared_length <= '0;
      stored_crc      <= '0;
    end else if (op_push) begin
      phase           <= phase_next;
      byte_index      <= byte_index_next;
      word_shift      <= word_shift_next;
      declared_length <= declared_length_next;
      stored_crc      <= stored_crc_next;
    end
  end
endmodule

// ----- rtl/trx_hdr_back.sv -----
module trx_hdr_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_empty,
  input  trx_hdr_pkg::op_t  op,
  output logic              op_pop,
  input  logic              res_full,
  output logic              res_push,
  output trx_hdr_pkg::res_t res
);
  import trx_hdr_pkg::*;

  logic [31:0] running_crc;
  logic [31:0] crc_base;
  logic [31:0] crc_next;
  logic        has_verdict;

  always_comb begin
    crc_base    = op.restart ? CRC_SEED : running_crc;
    crc_next    = op.crc_en ? crc_byte(crc_base, op.data) : crc_base;
    has_verdict = (op.kind != VK_NONE);
    // a transaction without a verdict never waits on the result side
    op_pop      = !op_empty && (!has_verdict || !res_full);
    res_push    = op_pop && has_verdict;

    res.crc    = crc_next;
    res.length = op.length;
    unique case (op.kind)
      VK_MAGIC:  res.status = ST_MAGIC;
      VK_LENGTH: res.status = ST_LENGTH;
      VK_CHECK:  res.status = (crc_next == op.stored_crc) ? ST_OK : ST_MISMATCH;
      default:   res.status = ST_TRUNC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CRC_SEED;
    end else if (op_pop) begin
      running_crc <= crc_next;
    end
  end
endmodule
